// File: rtl/tse_pkg.sv
package tse_pkg;

	localparam int COUNT_BITS = 20;
	localparam int LANES      = 3;
	localparam int TOTAL_BITS = COUNT_BITS + 2;
	localparam int POS_BITS   = 5;
	localparam int MILLI      = 1000;
	localparam int MILLI_BITS = 10;
	localparam int MULT_BITS  = TOTAL_BITS + MILLI_BITS;
	localparam int LOG_BITS   = 15;
	localparam int PROD_BITS  = COUNT_BITS + LOG_BITS;
	localparam int QUO_BITS   = 15;
	localparam int SUM_BITS   = QUO_BITS + 2;
	localparam int OUT_BITS   = 15;
	localparam int FRONT_STAGES = 5;
	localparam int LATENCY    = FRONT_STAGES + QUO_BITS + 1;

	typedef struct packed {
		logic                valid;
		logic [LOG_BITS-1:0] total_log;
		logic [LANES-1:0]    nz;
	} tse_side_t;

	// position of the leading one; zero for 0 and 1
	function automatic logic [POS_BITS-1:0] lead_pos(input logic [TOTAL_BITS-1:0] v);
		logic [POS_BITS-1:0] p;
		p = '0;
		for (int i = 0; i < TOTAL_BITS; i++) begin
			if (v[i]) begin
				p = POS_BITS'(i);
			end
		end
		return p;
	endfunction

endpackage

// File: rtl/tse_div.sv
module tse_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  tse_pkg::tse_side_t                        side_in,
	input  logic [tse_pkg::LANES-1:0][tse_pkg::PROD_BITS-1:0] num,
	input  logic [tse_pkg::TOTAL_BITS-1:0]            den,
	output tse_pkg::tse_side_t                        side_out,
	output logic [tse_pkg::LANES-1:0][tse_pkg::QUO_BITS-1:0]  quo
);
	import tse_pkg::*;

	tse_side_t                            side_s [QUO_BITS+1];
	logic [LANES-1:0][PROD_BITS-1:0]      rem_s  [QUO_BITS+1];
	logic [LANES-1:0][QUO_BITS-1:0]       quo_s  [QUO_BITS+1];
	logic [TOTAL_BITS-1:0]                den_s  [QUO_BITS+1];

	assign side_s[0] = side_in;
	assign rem_s[0]  = num;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;

	// one quotient bit per stage, most significant first
	for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
		localparam int K = QUO_BITS - 1 - g;
		logic [PROD_BITS:0]               dsh;
		logic [LANES-1:0][PROD_BITS-1:0]  rem_nx;
		logic [LANES-1:0][QUO_BITS-1:0]   quo_nx;

		always_comb begin
			dsh    = (PROD_BITS+1)'(den_s[g]) << K;
			rem_nx = rem_s[g];
			quo_nx = quo_s[g];
			for (int l = 0; l < LANES; l++) begin
				if ({1'b0, rem_s[g][l]} >= dsh) begin
					rem_nx[l]    = rem_s[g][l] - dsh[PROD_BITS-1:0];
					quo_nx[l][K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g+1] <= '0;
			end else begin
				side_s[g+1] <= side_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_nx;
			quo_s[g+1] <= quo_nx;
			den_s[g+1] <= den_s[g];
		end
	end

	assign side_out = side_s[QUO_BITS];
	assign quo      = quo_s[QUO_BITS];

endmodule

// File: rtl/ternary_shannon_entropy_core.sv
// Throughput: one item per cycle; busy is always low.
// Pipeline: 5 front stages (sum, leading one, scale, log, product), 15 divider
// stages of one quotient bit each for the three lanes, one output stage.
// Reset: arst_n clears every valid bit at once; no item survives a reset.
// Results are not stalled: done marks each result for exactly one cycle.
module ternary_shannon_entropy_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [tse_pkg::COUNT_BITS-1:0]   neg_count,
	input  logic [tse_pkg::COUNT_BITS-1:0]   zero_count,
	input  logic [tse_pkg::COUNT_BITS-1:0]   pos_count,
	output logic                             done,
	output logic [tse_pkg::OUT_BITS-1:0]     entropy_millibits
);
	import tse_pkg::*;

	// Lane index LANES is the total; lanes 0..2 are the counts.
	localparam int NV = LANES + 1;

	// Stage 1: capture counts, form the total
	logic                               valid_s1;
	logic [NV-1:0][TOTAL_BITS-1:0]      val_s1;

	// Stage 2: leading-one position and remainder below it
	logic                               valid_s2;
	logic [NV-1:0][POS_BITS-1:0]        pos_s2;
	logic [NV-1:0][TOTAL_BITS-1:0]      rem_s2;
	logic [LANES-1:0][COUNT_BITS-1:0]   cnt_s2;
	logic [TOTAL_BITS-1:0]              tot_s2;

	// Stage 3: remainder times 1000 and integer part times 1000
	logic                               valid_s3;
	logic [NV-1:0][MULT_BITS-1:0]       scl_s3;
	logic [NV-1:0][LOG_BITS-1:0]        ipart_s3;
	logic [NV-1:0][POS_BITS-1:0]        pos_s3;
	logic [LANES-1:0][COUNT_BITS-1:0]   cnt_s3;
	logic [TOTAL_BITS-1:0]              tot_s3;

	// Stage 4: log values
	logic                               valid_s4;
	logic [NV-1:0][LOG_BITS-1:0]        log_s4;
	logic [LANES-1:0][COUNT_BITS-1:0]   cnt_s4;
	logic [TOTAL_BITS-1:0]              tot_s4;

	// Stage 5: count times its log, ready for the divider
	tse_side_t                          side_s5;
	logic [LANES-1:0][PROD_BITS-1:0]    prod_s5;
	logic [TOTAL_BITS-1:0]              tot_s5;

	tse_side_t                          side_dv;
	logic [LANES-1:0][QUO_BITS-1:0]     quo_dv;

	logic                               done_q;
	logic [OUT_BITS-1:0]                ent_q;

	logic [SUM_BITS-1:0]                term_sum;
	logic [SUM_BITS-1:0]                log_ext;

	// Nothing ever holds the pipeline, so take a new item in every cycle.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			side_s5  <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			side_s5.valid <= valid_s4;
			side_s5.total_log <= log_s4[LANES];
			for (int l = 0; l < LANES; l++) begin
				side_s5.nz[l] <= cnt_s4[l] != '0;
			end
			done_q <= side_dv.valid;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1
		val_s1[0] <= TOTAL_BITS'(neg_count);
		val_s1[1] <= TOTAL_BITS'(zero_count);
		val_s1[2] <= TOTAL_BITS'(pos_count);
		val_s1[LANES] <= TOTAL_BITS'(neg_count) + TOTAL_BITS'(zero_count)
			+ TOTAL_BITS'(pos_count);

		// stage 2: clear the leading one to leave the remainder
		for (int v = 0; v < NV; v++) begin
			pos_s2[v] <= lead_pos(val_s1[v]);
			rem_s2[v] <= val_s1[v] & ~(TOTAL_BITS'(1) << lead_pos(val_s1[v]));
		end
		for (int l = 0; l < LANES; l++) begin
			cnt_s2[l] <= val_s1[l][COUNT_BITS-1:0];
		end
		tot_s2 <= val_s1[LANES];

		// stage 3
		for (int v = 0; v < NV; v++) begin
			scl_s3[v]   <= MULT_BITS'(rem_s2[v]) * MULT_BITS'(MILLI);
			ipart_s3[v] <= LOG_BITS'(pos_s2[v]) * LOG_BITS'(MILLI);
			pos_s3[v]   <= pos_s2[v];
		end
		cnt_s3 <= cnt_s2;
		tot_s3 <= tot_s2;

		// stage 4: fraction is floor of the scaled remainder over 2^p
		for (int v = 0; v < NV; v++) begin
			log_s4[v] <= ipart_s3[v] + LOG_BITS'(scl_s3[v] >> pos_s3[v]);
		end
		cnt_s4 <= cnt_s3;
		tot_s4 <= tot_s3;

		// stage 5
		for (int l = 0; l < LANES; l++) begin
			prod_s5[l] <= PROD_BITS'(cnt_s4[l]) * PROD_BITS'(log_s4[l]);
		end
		tot_s5 <= tot_s4;

		ent_q <= (log_ext > term_sum) ? OUT_BITS'(log_ext - term_sum) : '0;
	end

	tse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_s5),
		.num      (prod_s5),
		.den      (tot_s5),
		.side_out (side_dv),
		.quo      (quo_dv)
	);

	// Drop terms of empty counts; a zero total leaves every lane empty and log 0.
	always_comb begin
		term_sum = '0;
		for (int l = 0; l < LANES; l++) begin
			if (side_dv.nz[l]) begin
				term_sum = term_sum + SUM_BITS'(quo_dv[l]);
			end
		end
		log_ext = SUM_BITS'(side_dv.total_log);
	end

	assign done              = done_q;
	assign entropy_millibits = ent_q;

endmodule

// File: rtl/tse_checker.sv
module tse_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [tse_pkg::COUNT_BITS-1:0]   neg_count,
	input logic [tse_pkg::COUNT_BITS-1:0]   zero_count,
	input logic [tse_pkg::COUNT_BITS-1:0]   pos_count,
	input logic                             done,
	input logic [tse_pkg::OUT_BITS-1:0]     entropy_millibits
);
	import tse_pkg::*;

	localparam int CNT_BITS = $clog2(LATENCY + 1);
	localparam logic [OUT_BITS-1:0] MAX_ENT = OUT_BITS'(21999);

	// cycles since reset release, saturating at the latency
	logic [CNT_BITS-1:0] since_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
		end else if (since_q != CNT_BITS'(LATENCY)) begin
			since_q <= since_q + CNT_BITS'(1);
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_item_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(since_q == CNT_BITS'(LATENCY)) && $past(start && !busy, LATENCY) |-> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entropy_millibits <= MAX_ENT)
		else $error("entropy out of range");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(neg_count == '0 && zero_count == '0 && pos_count == '0, LATENCY)
		|-> entropy_millibits == '0)
		else $error("empty distribution gave nonzero entropy");

endmodule

bind ternary_shannon_entropy_core tse_checker u_tse_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.neg_count         (neg_count),
	.zero_count        (zero_count),
	.pos_count         (pos_count),
	.done              (done),
	.entropy_millibits (entropy_millibits)
);

// File: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tse_pkg::*;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [OUT_BITS-1:0]   entropy_t;

	// Scoreboard: predicts entropy for each accepted triple, matches done results in order.
	class entropy_board;
		entropy_t pending_q[$];
		int       mismatches;
		int       matched;

		// approximate log2 in millibits: leading-one position plus linear fraction
		static function longint unsigned log_milli(longint unsigned v);
			longint unsigned t;
			int              p;
			t = v;
			p = 0;
			if (v <= 1) begin
				return 0;
			end
			while (t > 1) begin
				t = t >> 1;
				p++;
			end
			return longint'(p) * MILLI + (((v - (64'd1 << p)) * MILLI) >> p);
		endfunction

		static function entropy_t predict(count_t n, count_t z, count_t q);
			longint unsigned c[3];
			longint unsigned total;
			longint unsigned total_log;
			longint unsigned sum;
			c[0] = n;
			c[1] = z;
			c[2] = q;
			total = c[0] + c[1] + c[2];
			sum = 0;
			if (total == 0) begin
				return '0;
			end
			total_log = log_milli(total);
			for (int i = 0; i < 3; i++) begin
				if (c[i] != 0) begin
					sum += (c[i] * log_milli(c[i])) / total;
				end
			end
			return (total_log > sum) ? entropy_t'(total_log - sum) : '0;
		endfunction

		function void note_item(count_t n, count_t z, count_t q);
			pending_q.push_back(predict(n, z, q));
		endfunction

		function void check_result(entropy_t got);
			entropy_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, got);
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			if (got !== want) begin
				$display("%0t: entropy_millibits mismatch, expected %0d, actual %0d",
					$time, want, got);
				mismatches++;
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	count_t   neg_count;
	count_t   zero_count;
	count_t   pos_count;
	logic     done;
	entropy_t entropy_millibits;

	entropy_board board;
	int           sent;
	bit           quiet_tail;

	ternary_shannon_entropy_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.neg_count         (neg_count),
		.zero_count        (zero_count),
		.pos_count         (pos_count),
		.done              (done),
		.entropy_millibits (entropy_millibits)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Sample results on the edge that ends the done cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(entropy_millibits);
		end
	end

	// Present one item and hold it until an edge accepts it.
	task automatic send_item(count_t n, count_t z, count_t q);
		start      <= 1'b1;
		neg_count  <= n;
		zero_count <= z;
		pos_count  <= q;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		board.note_item(n, z, q);
		sent++;
	endtask

	// Drop start for a burst of idle cycles.
	task automatic idle_burst();
		int gap;
		gap = $urandom_range(1, 11);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Random count with a spread of magnitudes: zero, tiny, powers of two, all ones, random widths.
	function automatic count_t rand_count();
		int pick;
		int bits;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				return '0;
			end
			1: begin
				return count_t'($urandom_range(1, 3));
			end
			2: begin
				return count_t'(1) << $urandom_range(0, COUNT_BITS - 1);
			end
			3: begin
				return '1;
			end
			default: begin
				bits = $urandom_range(1, COUNT_BITS);
				return count_t'($urandom) & count_t'((64'd1 << bits) - 1);
			end
		endcase
	endfunction

	initial begin
		count_t dir_q[$][3];
		count_t n;
		count_t z;
		count_t q;
		int     wait_cycles;

		board      = new();
		sent       = 0;
		quiet_tail = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		neg_count  = '0;
		zero_count = '0;
		pos_count  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty total, single symbol, lone nonzero lanes, even splits, full scale.
		dir_q = '{
			'{20'd0, 20'd0, 20'd0},
			'{20'd1, 20'd0, 20'd0},
			'{20'd0, 20'd1, 20'd0},
			'{20'd0, 20'd0, 20'd1},
			'{20'd1, 20'd1, 20'd0},
			'{20'd1, 20'd1, 20'd1},
			'{20'd2, 20'd2, 20'd2},
			'{20'd3, 20'd5, 20'd7},
			'{20'd1000, 20'd0, 20'd0},
			'{20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
			'{20'hFFFFF, 20'd0, 20'd0},
			'{20'hFFFFF, 20'd1, 20'd0},
			'{20'd0, 20'hFFFFF, 20'hFFFFF},
			'{20'h80000, 20'h80000, 20'h80000},
			'{20'h7FFFF, 20'h80000, 20'h00001},
			'{20'd1, 20'd1, 20'hFFFFF},
			'{20'd3, 20'd0, 20'd1},
			'{20'd5, 20'd6, 20'd7},
			'{20'd100, 20'd200, 20'd300},
			'{20'hAAAAA, 20'h55555, 20'hAAAAA},
			'{20'h55555, 20'hAAAAA, 20'h55555}
		};
		foreach (dir_q[i]) begin
			send_item(dir_q[i][0], dir_q[i][1], dir_q[i][2]);
		end

		// Random triples; idle bursts stop for the last part of the run.
		for (int k = 0; k < 1950; k++) begin
			quiet_tail = (k >= 1650);
			n = rand_count();
			z = rand_count();
			q = rand_count();
			send_item(n, z, q);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				idle_burst();
			end
		end
		start <= 1'b0;

		// Drain the pipeline until every predicted result has come back, with a bound on the wait.
		wait_cycles = 0;
		while (board.pending_q.size() != 0 && wait_cycles < 4 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);

		$display("Sent %0d count triples (directed extremes plus random spreads),", sent);
		$display("matched %0d entropy results, %0d left pending.",
			board.matched, board.pending_q.size());
		if (board.mismatches == 0 && board.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#2ms;
		$display("Timeout waiting for the block.");
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tse_pkg.sv
rtl/tse_div.sv
rtl/ternary_shannon_entropy_core.sv
rtl/tse_checker.sv
bench/testbench.sv
